// File: src/tmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmq_pkg
// Shared types and constants of the sorted expiry timer queue.
// ----------------------------------------------------------------------------
package tmq_pkg;

  localparam int FUNC_W    = 2;
  localparam int ID_W      = 6;
  localparam int IN_TIME_W = 32;
  localparam int STATUS_W  = 2;
  localparam int MAX_RUN   = 64;
  localparam int RUN_W     = $clog2(MAX_RUN + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_ADJUST = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_TICK   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_DUP    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DEL_RD,
    S_DEL_MV,
    S_INS_BEG,
    S_INS_MV,
    S_INS_PUT,
    S_TICK_RD,
    S_TICK_CMP,
    S_TICK_END,
    S_RESP
  } seq_state_t;

  typedef struct packed {
    logic mem_we;
    logic mem_re;
    logic act_we;
    logic act_val;
  } store_ctrl_t;

endpackage

// File: src/tmq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmq_req_if / tmq_rsp_if
// Valid/ready channels for timer operations and their results.
// ----------------------------------------------------------------------------
interface tmq_req_if
  import tmq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [ID_W-1:0]      timer_id;
  logic [IN_TIME_W-1:0] expire_time;
  logic [IN_TIME_W-1:0] current_time;

  modport source (output valid, func, timer_id, expire_time, current_time, input ready);
  modport sink (input valid, func, timer_id, expire_time, current_time, output ready);
endinterface

interface tmq_rsp_if
  import tmq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                expired_valid;
  logic [ID_W-1:0]     expired_id;
  logic                last;

  modport source (output valid, status, expired_valid, expired_id, last, input ready);
  modport sink (input valid, status, expired_valid, expired_id, last, output ready);
endinterface

// File: src/tmq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmq_store
// Sorted entry memory (id and expiry) and per-slot active flags.
// ----------------------------------------------------------------------------
module tmq_store
  import tmq_pkg::*;
#(
  parameter int NUM_TIMERS = 64,
  parameter int TIME_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  store_ctrl_t         ctrl,
  input  logic [$clog2(NUM_TIMERS)-1:0] raddr,
  input  logic [$clog2(NUM_TIMERS)-1:0] waddr,
  input  logic [ID_W-1:0]     wr_id,
  input  logic [TIME_BITS-1:0] wr_exp,
  output logic [ID_W-1:0]     rd_id,
  output logic [TIME_BITS-1:0] rd_exp,
  input  logic [$clog2((NUM_TIMERS < (1 << ID_W)) ? NUM_TIMERS : (1 << ID_W))-1:0] act_raddr,
  input  logic [$clog2((NUM_TIMERS < (1 << ID_W)) ? NUM_TIMERS : (1 << ID_W))-1:0] act_waddr,
  output logic                act_q
);

  localparam int PW        = $clog2(NUM_TIMERS);
  localparam int MEM_DEPTH = 1 << PW;
  localparam int SLOTS     = (NUM_TIMERS < (1 << ID_W)) ? NUM_TIMERS : (1 << ID_W);

  logic [ID_W-1:0]      mem_id  [MEM_DEPTH];
  logic [TIME_BITS-1:0] mem_exp [MEM_DEPTH];
  logic [SLOTS-1:0]     slot_active;

  always_ff @(posedge clk) begin
    if (ctrl.mem_we) begin
      mem_id[waddr]  <= wr_id;
      mem_exp[waddr] <= wr_exp;
    end
    if (ctrl.mem_re) begin
      rd_id  <= mem_id[raddr];
      rd_exp <= mem_exp[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
    end else if (ctrl.act_we) begin
      slot_active[act_waddr] <= ctrl.act_val;
    end
  end

  assign act_q = slot_active[act_raddr];

endmodule

// File: src/tmq_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmq_seq
// Operation sequencer with the shared expiry comparator and result register.
// ----------------------------------------------------------------------------
module tmq_seq
  import tmq_pkg::*;
#(
  parameter int NUM_TIMERS = 64,
  parameter int TIME_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst,
  tmq_req_if.sink             req,
  tmq_rsp_if.source           rsp,
  output store_ctrl_t         ctrl,
  output logic [$clog2(NUM_TIMERS)-1:0] raddr,
  output logic [$clog2(NUM_TIMERS)-1:0] waddr,
  output logic [ID_W-1:0]     wr_id,
  output logic [TIME_BITS-1:0] wr_exp,
  input  logic [ID_W-1:0]     rd_id,
  input  logic [TIME_BITS-1:0] rd_exp,
  output logic [$clog2((NUM_TIMERS < (1 << ID_W)) ? NUM_TIMERS : (1 << ID_W))-1:0] act_raddr,
  output logic [$clog2((NUM_TIMERS < (1 << ID_W)) ? NUM_TIMERS : (1 << ID_W))-1:0] act_waddr,
  input  logic                act_q
);

  localparam int PW    = $clog2(NUM_TIMERS);
  localparam int CW    = $clog2(NUM_TIMERS + 1);
  localparam int SLOTS = (NUM_TIMERS < (1 << ID_W)) ? NUM_TIMERS : (1 << ID_W);
  localparam int SW    = $clog2(SLOTS);

  seq_state_t           state, state_next;
  func_t                op, op_next;
  logic [ID_W-1:0]      id, id_next;
  logic [TIME_BITS-1:0] exp, exp_next;
  logic [TIME_BITS-1:0] now, now_next;
  logic [CW-1:0]        count, count_next;
  logic [PW-1:0]        head, head_next;
  logic [PW-1:0]        pos, pos_next;
  logic                 found, found_next;
  logic [RUN_W-1:0]     k, k_next;
  logic                 pend_valid, pend_valid_next;
  logic [ID_W-1:0]      pend_id, pend_id_next;
  status_t              status_r, status_next;

  logic                 o_valid;
  status_t              o_status;
  logic                 o_exp_valid;
  logic [ID_W-1:0]      o_exp_id;
  logic                 o_last;

  logic                 emit;
  status_t              e_status;
  logic                 e_valid;
  logic [ID_W-1:0]      e_id;
  logic                 e_last;

  logic                 can_emit;
  logic [TIME_BITS-1:0] cmp_b;
  logic                 le;
  logic                 id_ok;
  logic                 del_last;

  // shared compare unit
  assign cmp_b    = (state == S_TICK_CMP) ? now : exp;
  assign le       = rd_exp <= cmp_b;
  assign can_emit = !o_valid || rsp.ready;
  assign id_ok    = 32'(id) < NUM_TIMERS;
  assign del_last = (CW'(pos) + CW'(1)) == count;
  assign act_raddr = id[SW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      head       <= '0;
      pend_valid <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      head       <= head_next;
      pend_valid <= pend_valid_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    id       <= id_next;
    exp      <= exp_next;
    now      <= now_next;
    pos      <= pos_next;
    found    <= found_next;
    k        <= k_next;
    pend_id  <= pend_id_next;
    status_r <= status_next;
    if (emit) begin
      o_status    <= e_status;
      o_exp_valid <= e_valid;
      o_exp_id    <= e_id;
      o_last      <= e_last;
    end
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    id_next         = id;
    exp_next        = exp;
    now_next        = now;
    count_next      = count;
    head_next       = head;
    pos_next        = pos;
    found_next      = found;
    k_next          = k;
    pend_valid_next = pend_valid;
    pend_id_next    = pend_id;
    status_next     = status_r;
    ctrl            = '0;
    raddr           = head + pos;
    waddr           = head + pos;
    wr_id           = id;
    wr_exp          = exp;
    act_waddr       = id[SW-1:0];
    emit            = 1'b0;
    e_status        = ST_OK;
    e_valid         = 1'b0;
    e_id            = '0;
    e_last          = 1'b1;
    req.ready       = 1'b0;

    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          op_next    = func_t'(req.func);
          id_next    = req.timer_id;
          exp_next   = TIME_BITS'(req.expire_time);
          now_next   = TIME_BITS'(req.current_time);
          state_next = S_CHECK;
        end
      end

      S_CHECK: begin
        status_next     = ST_OK;
        pos_next        = '0;
        found_next      = 1'b0;
        k_next          = '0;
        pend_valid_next = 1'b0;
        if (op == FUNC_TICK) begin
          state_next = S_TICK_RD;
        end else if (!id_ok) begin
          status_next = ST_ABSENT;
          state_next  = S_RESP;
        end else if (op == FUNC_ADD) begin
          if (act_q) begin
            status_next = ST_DUP;
            state_next  = S_RESP;
          end else if (count == CW'(NUM_TIMERS)) begin
            status_next = ST_FULL;
            state_next  = S_RESP;
          end else begin
            state_next = S_INS_BEG;
          end
        end else if (!act_q) begin
          status_next = ST_ABSENT;
          state_next  = S_RESP;
        end else begin
          state_next = S_DEL_RD;
        end
      end

      S_DEL_RD: begin
        ctrl.mem_re = 1'b1;
        state_next  = S_DEL_MV;
      end

      S_DEL_MV: begin
        if (found) begin
          ctrl.mem_we = 1'b1;
          waddr       = head + pos - PW'(1);
          wr_id       = rd_id;
          wr_exp      = rd_exp;
        end
        if (del_last) begin
          count_next = count - CW'(1);
          if (op == FUNC_DELETE) begin
            ctrl.act_we  = 1'b1;
            ctrl.act_val = 1'b0;
            state_next   = S_RESP;
          end else begin
            state_next = S_INS_BEG;
          end
        end else begin
          ctrl.mem_re = 1'b1;
          raddr       = head + pos + PW'(1);
          pos_next    = pos + PW'(1);
          found_next  = found || (rd_id == id);
        end
      end

      S_INS_BEG: begin
        if (count == '0) begin
          state_next = S_INS_PUT;
        end else begin
          ctrl.mem_re = 1'b1;
          pos_next    = PW'(count - CW'(1));
          raddr       = head + PW'(count - CW'(1));
          state_next  = S_INS_MV;
        end
      end

      S_INS_MV: begin
        ctrl.mem_we = 1'b1;
        waddr       = head + pos + PW'(1);
        if (!le) begin
          wr_id  = rd_id;
          wr_exp = rd_exp;
          if (pos == '0) begin
            state_next = S_INS_PUT;
          end else begin
            ctrl.mem_re = 1'b1;
            raddr       = head + pos - PW'(1);
            pos_next    = pos - PW'(1);
          end
        end else begin
          count_next   = count + CW'(1);
          ctrl.act_we  = 1'b1;
          ctrl.act_val = 1'b1;
          state_next   = S_RESP;
        end
      end

      S_INS_PUT: begin
        ctrl.mem_we  = 1'b1;
        waddr        = head;
        count_next   = count + CW'(1);
        ctrl.act_we  = 1'b1;
        ctrl.act_val = 1'b1;
        state_next   = S_RESP;
      end

      S_TICK_RD: begin
        if (count != '0 && k < RUN_W'(MAX_RUN)) begin
          ctrl.mem_re = 1'b1;
          raddr       = head;
          state_next  = S_TICK_CMP;
        end else begin
          state_next = S_TICK_END;
        end
      end

      S_TICK_CMP: begin
        if (!le) begin
          state_next = S_TICK_END;
        end else if (!pend_valid || can_emit) begin
          if (pend_valid) begin
            emit    = 1'b1;
            e_valid = 1'b1;
            e_id    = pend_id;
            e_last  = 1'b0;
          end
          head_next       = head + PW'(1);
          count_next      = count - CW'(1);
          ctrl.act_we     = 1'b1;
          ctrl.act_val    = 1'b0;
          act_waddr       = rd_id[SW-1:0];
          pend_id_next    = rd_id;
          pend_valid_next = 1'b1;
          k_next          = k + RUN_W'(1);
          state_next      = S_TICK_RD;
        end
      end

      S_TICK_END: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_valid    = pend_valid;
          e_id       = pend_valid ? pend_id : '0;
          state_next = S_IDLE;
        end
      end

      S_RESP: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_status   = status_r;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign rsp.valid         = o_valid;
  assign rsp.status        = o_status;
  assign rsp.expired_valid = o_exp_valid;
  assign rsp.expired_id    = o_exp_id;
  assign rsp.last          = o_last;

endmodule

// File: src/sorted_expiry_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_expiry_timer_queue
// Timer queue kept in ascending expiry order with add, adjust, delete, tick.
// ----------------------------------------------------------------------------
// req carries one operation per transaction: func, timer_id, expire_time and
// current_time. rsp returns results; each operation ends with a result that
// has last set. Add, adjust and delete give one status result. Tick pops the
// due entries at the head, up to 64, and returns one result per popped id; a
// tick with nothing due gives one result with expired_valid low.
// Entries live in a circular memory; inserts and removals shift entries one
// per cycle through its single read and write port, with one comparator
// shared by the insert search and the tick expiry test. An adjust removes
// the entry and then inserts it anew. Results are registered on rsp, and req
// is ready again once the sequencer has registered an operation's last result.
// A stalled rsp holds its result; the sequencer waits on the next one.
// rst (synchronous) empties the queue and clears all slot flags at once.
// ----------------------------------------------------------------------------
module sorted_expiry_timer_queue
  import tmq_pkg::*;
#(
  parameter int NUM_TIMERS = 64,
  parameter int TIME_BITS  = 32
) (
  input logic       clk,
  input logic       rst,
  tmq_req_if.sink   req,
  tmq_rsp_if.source rsp
);

  localparam int PW    = $clog2(NUM_TIMERS);
  localparam int SLOTS = (NUM_TIMERS < (1 << ID_W)) ? NUM_TIMERS : (1 << ID_W);
  localparam int SW    = $clog2(SLOTS);

  store_ctrl_t          ctrl;
  logic [PW-1:0]        raddr;
  logic [PW-1:0]        waddr;
  logic [ID_W-1:0]      wr_id;
  logic [TIME_BITS-1:0] wr_exp;
  logic [ID_W-1:0]      rd_id;
  logic [TIME_BITS-1:0] rd_exp;
  logic [SW-1:0]        act_raddr;
  logic [SW-1:0]        act_waddr;
  logic                 act_q;

  tmq_seq #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIME_BITS  (TIME_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .ctrl      (ctrl),
    .raddr     (raddr),
    .waddr     (waddr),
    .wr_id     (wr_id),
    .wr_exp    (wr_exp),
    .rd_id     (rd_id),
    .rd_exp    (rd_exp),
    .act_raddr (act_raddr),
    .act_waddr (act_waddr),
    .act_q     (act_q)
  );

  tmq_store #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIME_BITS  (TIME_BITS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .raddr     (raddr),
    .waddr     (waddr),
    .wr_id     (wr_id),
    .wr_exp    (wr_exp),
    .rd_id     (rd_id),
    .rd_exp    (rd_exp),
    .act_raddr (act_raddr),
    .act_waddr (act_waddr),
    .act_q     (act_q)
  );

endmodule

// File: src/tmq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmq_checker
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module tmq_checker
  import tmq_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic                rsp_expired_valid,
  input logic [ID_W-1:0]     rsp_expired_id,
  input logic                rsp_last
);

  // busy after an accepted transaction
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while an operation is in progress");

  // a result without an expired id always ends its run
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_expired_valid |-> rsp_last && rsp_expired_id == '0)
    else $error("empty result not marked last or carries an id");

  // expired ids only come with ok status
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_expired_valid |-> rsp_status == ST_OK)
    else $error("expired id with error status");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_expired_valid) && $stable(rsp_expired_id) && $stable(rsp_last))
    else $error("stalled result changed");

endmodule

bind sorted_expiry_timer_queue tmq_checker u_tmq_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_expired_valid (rsp.expired_valid),
  .rsp_expired_id    (rsp.expired_id),
  .rsp_last          (rsp.last)
);
